>>> rtl/rqs_pkg.sv
`default_nettype none

package rqs_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CAP_W      = 5;
	localparam int ACTION_W   = 3;
	localparam int STATUS_W   = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ENQUEUE = 3'd0,
		ACT_DEQUEUE = 3'd1,
		ACT_PEEK    = 3'd2,
		ACT_CLEAR   = 3'd3,
		ACT_SEARCH  = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    enq;
		logic    deq;
		logic    clr;
		logic    scan_start;
		logic    scan_step;
		logic    rd_scan;
		logic    res_load;
		status_t res_status;
		logic    res_data;
		logic    res_slot;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic match;
		logic last;
	} sts_t;

	typedef struct packed {
		status_t                       status;
		logic signed [DATA_WIDTH-1:0]  data;
		logic [PTR_W-1:0]              slot_index;
		logic [CNT_W-1:0]              occupancy;
		logic                          is_empty;
		logic                          is_full;
	} res_t;

	// Next ring position; wraps to zero at the configured capacity.
	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] pos,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] nxt;
		nxt = CNT_W'(pos) + CNT_W'(1);
		return (nxt >= cap) ? '0 : nxt[PTR_W-1:0];
	endfunction

	// A written capacity of zero acts as one, anything above DEPTH as DEPTH.
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] raw);
		logic [CNT_W-1:0] res;
		if (raw == '0) begin
			res = CNT_W'(1);
		end else if (int'(raw) > DEPTH) begin
			res = CNT_W'(DEPTH);
		end else begin
			res = CNT_W'(raw);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

>>> rtl/rqs_req_if.sv
`default_nettype none

interface rqs_req_if;
	import rqs_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [ACTION_W-1:0]          action;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/rqs_res_if.sv
`default_nettype none

interface rqs_res_if;
	import rqs_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [STATUS_W-1:0]          status;
	logic signed [DATA_WIDTH-1:0] data;
	logic [PTR_W-1:0]             slot_index;
	logic [CNT_W-1:0]             occupancy;
	logic                         is_empty;
	logic                         is_full;

	modport source (output valid, output status, output data, output slot_index,
		output occupancy, output is_empty, output is_full, input ready);
	modport sink (input valid, input status, input data, input slot_index,
		input occupancy, input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

>>> rtl/ring_queue_with_search_core.sv
`default_nettype none

// Circular FIFO of 32-bit words with a run-time capacity of 1 to 16 slots and
// a search for a key from the oldest entry on. Enqueue, clear, refused
// requests and unused action codes return their result in the cycle after
// acceptance; dequeue and peek pass through the S_READ state because the
// slot memory has one registered read port. A search compares up to the
// occupancy entries, one memory read per slot. A new request is accepted
// when the block is idle and the result register is empty or being taken in
// the same cycle. Writing the capacity empties the queue.
module ring_queue_with_search_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [rqs_pkg::CAP_W-1:0] cfg_wdata,
	rqs_req_if.sink                        req,
	rqs_res_if.source                      res
);
	import rqs_pkg::*;

	cmd_t cmd;
	sts_t sts;
	res_t res_word;

	rqs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.res_valid  (res.valid),
		.res_ready  (res.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	rqs_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.value     (req.value),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res_word)
	);

	assign res.status     = res_word.status;
	assign res.data       = res_word.data;
	assign res.slot_index = res_word.slot_index;
	assign res.occupancy  = res_word.occupancy;
	assign res.is_empty   = res_word.is_empty;
	assign res.is_full    = res_word.is_full;

endmodule

`default_nettype wire

>>> rtl/rqs_dpath.sv
`default_nettype none

module rqs_dpath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [rqs_pkg::CAP_W-1:0]             cfg_wdata,
	input  wire logic signed [rqs_pkg::DATA_WIDTH-1:0] value,
	input  wire rqs_pkg::cmd_t                         cmd,
	output rqs_pkg::sts_t                              sts,
	output rqs_pkg::res_t                              res
);
	import rqs_pkg::*;

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [PTR_W-1:0]      rd_addr;

	logic [PTR_W-1:0]      head_q;
	logic [PTR_W-1:0]      tail_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      cap_q;
	logic [CNT_W-1:0]      cnt_next;

	logic [PTR_W-1:0]      scan_pos_q;
	logic [PTR_W-1:0]      cmp_pos_q;
	logic [CNT_W-1:0]      rem_q;
	logic [DATA_WIDTH-1:0] key_q;

	assign rd_addr = cmd.rd_scan ? scan_pos_q : head_q;

	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			mem_q[tail_q] <= value;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_comb begin
		cnt_next = cnt_q;
		if (cmd.clr) begin
			cnt_next = '0;
		end else if (cmd.enq) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (cmd.deq) begin
			cnt_next = cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			cap_q  <= CNT_W'(DEPTH);
		end else if (cfg_we) begin
			// A new capacity empties the queue; slot contents stay.
			cap_q  <= eff_cap(cfg_wdata);
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			cnt_q <= cnt_next;
			if (cmd.clr) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (cmd.enq) begin
					tail_q <= adv(tail_q, cap_q);
				end
				if (cmd.deq) begin
					head_q <= adv(head_q, cap_q);
				end
			end
		end
	end

	// The scan keeps one read in flight: cmp_pos_q names the slot whose word
	// sits in rd_data_q, scan_pos_q the slot being read now.
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			key_q      <= value;
			cmp_pos_q  <= head_q;
			scan_pos_q <= adv(head_q, cap_q);
			rem_q      <= cnt_q;
		end else if (cmd.scan_step) begin
			cmp_pos_q  <= scan_pos_q;
			scan_pos_q <= adv(scan_pos_q, cap_q);
			rem_q      <= rem_q - CNT_W'(1);
		end
		if (cmd.res_load) begin
			res.status     <= cmd.res_status;
			res.data       <= cmd.res_data ? rd_data_q : '0;
			res.slot_index <= cmd.res_slot ? cmp_pos_q : '0;
			res.occupancy  <= cnt_next;
			res.is_empty   <= (cnt_next == '0);
			res.is_full    <= (cnt_next == cap_q);
		end
	end

	assign sts.empty = (cnt_q == '0);
	assign sts.full  = (cnt_q >= cap_q);
	assign sts.match = (rd_data_q == key_q);
	assign sts.last  = (rem_q == CNT_W'(1));

`ifndef ASSERT_OFF
	a_cnt_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cap_q) else $error("occupancy exceeds capacity");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> head_q == tail_q) else $error("empty queue with head and tail apart");
	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq && !cfg_we |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("enqueue did not raise occupancy");
`endif

endmodule

`default_nettype wire

>>> rtl/rqs_ctrl.sv
`default_nettype none

module rqs_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	input  wire logic [rqs_pkg::ACTION_W-1:0]  req_action,
	output logic                               req_ready,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	input  wire rqs_pkg::sts_t                 sts,
	output rqs_pkg::cmd_t                      cmd
);
	import rqs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   res_valid_q;
	logic   accept;

	// The result register may be refilled in the cycle its request is taken.
	assign req_ready = (state_q == S_IDLE) && (!res_valid_q || res_ready);
	assign accept    = req_valid && req_ready;
	assign res_valid = res_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.res_status = ST_OK;
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (action_t'(req_action))
						ACT_ENQUEUE: begin
							cmd.res_load = 1'b1;
							if (sts.full) begin
								cmd.res_status = ST_FULL;
							end else begin
								cmd.enq = 1'b1;
							end
						end
						ACT_DEQUEUE: begin
							if (sts.empty) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = ST_EMPTY;
							end else begin
								cmd.deq    = 1'b1;
								state_next = S_READ;
							end
						end
						ACT_PEEK: begin
							if (sts.empty) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = ST_EMPTY;
							end else begin
								state_next = S_READ;
							end
						end
						ACT_CLEAR: begin
							cmd.clr      = 1'b1;
							cmd.res_load = 1'b1;
						end
						ACT_SEARCH: begin
							if (sts.empty) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = ST_NOT_FOUND;
							end else begin
								cmd.scan_start = 1'b1;
								state_next     = S_SCAN;
							end
						end
						default: begin
							cmd.res_load = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				cmd.res_load = 1'b1;
				cmd.res_data = 1'b1;
				state_next   = S_IDLE;
			end
			S_SCAN: begin
				cmd.rd_scan = 1'b1;
				if (sts.match) begin
					cmd.res_load = 1'b1;
					cmd.res_slot = 1'b1;
					state_next   = S_IDLE;
				end else if (sts.last) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					state_next     = S_IDLE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !res_valid_q) else $error("result pending while busy");
	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_IDLE && res_valid_q)
		else $error("read did not complete in one cycle");
	a_match_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && sts.match |=> res_valid_q && state_q == S_IDLE)
		else $error("search match did not produce a result");
`endif

endmodule

`default_nettype wire
